// ===== hw/rtl/dfr_pkg.sv =====
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int unsigned CfgWidth = 18;
  localparam logic [CfgWidth-1:0] MaxPayloadReset = 18'(128 * 1024);

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcAllOnes = 32'hFFFFFFFF;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_END     = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic        first_of_payload;
    logic [1:0]  frame_status;
    logic [31:0] frame_length;
  } dfr_result_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/length_prefixed_crc32_deframer_core.sv =====
`timescale 1ns / 1ps
// channel   | ports                          | handshake
// ----------+--------------------------------+------------------------
// in        | in_rx_byte                     | in_valid / in_ready
// out       | out_result_kind .. _length     | out_valid / out_ready
// cfg       | cfg_max_payload_len            | cfg_write_en, no wait
//
// one byte per cycle sustained while the result side keeps up; a byte is taken into the
// input register, then crc and parse logic write its result into the result register
// a header or crc byte that ends no frame gives no result
// reset is synchronous; the crc register comes up all ones, limit at 128k
// a stalled result holds a byte that makes a result in the input register,
// and with that register full the input is held too

module length_prefixed_crc32_deframer_core #(
  parameter int unsigned MAX_FRAME_BYTES = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_first_of_payload,
  output logic [1:0]  out_frame_status,
  output logic [31:0] out_frame_length,
  input  logic        cfg_write_en,
  input  logic [dfr_pkg::CfgWidth-1:0] cfg_max_payload_len
);

  import dfr_pkg::*;

  logic [CfgWidth-1:0] max_len_r;
  logic                stage_valid;
  logic [7:0]          stage_byte;
  logic                advance;
  logic                res_valid;
  logic                out_free;
  dfr_result_t         res;
  dfr_result_t         res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxPayloadReset;
    end else if (cfg_write_en) begin
      max_len_r <= cfg_max_payload_len;
    end
  end

  // byte moves on unless it makes a result and the result register is full
  assign advance = stage_valid && (!res_valid || out_free);

  dfr_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  dfr_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .rx_byte         (stage_byte),
    .max_payload_len (max_len_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  dfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res_in    (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_result_kind      = res_q.result_kind;
  assign out_payload_byte     = res_q.payload_byte;
  assign out_first_of_payload = res_q.first_of_payload;
  assign out_frame_status     = res_q.frame_status;
  assign out_frame_length     = res_q.frame_length;

endmodule

// ===== hw/rtl/dfr_in_stage.sv =====
`timescale 1ns / 1ps

module dfr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== hw/rtl/dfr_parser.sv =====
`timescale 1ns / 1ps

module dfr_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 131072
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  rx_byte,
  input  logic [dfr_pkg::CfgWidth-1:0] max_payload_len,
  output logic                        res_valid,
  output dfr_pkg::dfr_result_t        res
);

  import dfr_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CRC     = 2'd2;

  localparam logic [31:0] MaxFrame = 32'(MAX_FRAME_BYTES);

  logic [1:0]          phase_r, phase_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [31:0]         len_r, len_nxt;
  logic [CfgWidth-1:0] left_r, left_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic [31:0]         rcrc_r, rcrc_nxt;
  logic [31:0]         limit;
  logic [31:0]         max_len_ext;

  assign max_len_ext = {{(32-CfgWidth){1'b0}}, max_payload_len};
  assign limit       = (MaxFrame < max_len_ext) ? MaxFrame : max_len_ext;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_PAYLOAD: begin
        res_valid            = 1'b1;
        res.result_kind      = KIND_PAYLOAD;
        res.payload_byte     = rx_byte;
        res.first_of_payload = ({{(32-CfgWidth){1'b0}}, left_r} == len_r);
        crc_nxt  = crc_byte(crc_r, rx_byte);
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          phase_nxt = PH_CRC;
          cnt_nxt   = 2'd0;
          rcrc_nxt  = '0;
        end
      end
      PH_CRC: begin
        rcrc_nxt = {rcrc_r[23:0], rx_byte};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_nxt == 2'd0) begin
          res_valid        = 1'b1;
          res.result_kind  = KIND_END;
          res.frame_status = ((crc_r ^ CrcAllOnes) == rcrc_nxt) ? ST_OK : ST_CRC_ERR;
          res.frame_length = len_r;
          phase_nxt        = PH_HEADER;
          crc_nxt          = CrcAllOnes;
        end
      end
      default: begin
        // header, and the unused phase code
        phase_nxt = PH_HEADER;
        len_nxt   = {len_r[23:0], rx_byte};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_nxt == 2'd0) begin
          crc_nxt  = CrcAllOnes;
          rcrc_nxt = '0;
          if (len_nxt > limit) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_END;
            res.frame_status = ST_TOO_LONG;
            res.frame_length = len_nxt;
          end else begin
            left_nxt  = len_nxt[CfgWidth-1:0];
            phase_nxt = (len_nxt[CfgWidth-1:0] == '0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= 2'd0;
      len_r   <= '0;
      left_r  <= '0;
      crc_r   <= CrcAllOnes;
      rcrc_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

// ===== hw/rtl/dfr_out_stage.sv =====
`timescale 1ns / 1ps

module dfr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  dfr_pkg::dfr_result_t res_in,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dfr_pkg::dfr_result_t res_out
);

  import dfr_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  dfr_result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      res_r <= res_in;
    end
  end

endmodule

// ===== hw/rtl/dfr_checker.sv =====
`timescale 1ns / 1ps

module dfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [7:0]  out_payload_byte,
  input logic        out_first_of_payload,
  input logic [1:0]  out_frame_status,
  input logic [31:0] out_frame_length
);

  import dfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_payload_byte) && $stable(out_frame_length))
    else $error("result changed while stalled");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PAYLOAD |->
      out_frame_status == ST_OK && out_frame_length == 32'd0)
    else $error("payload beat carries frame status");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_END |->
      out_payload_byte == 8'd0 && !out_first_of_payload)
    else $error("end beat carries payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_END |->
      out_frame_status == ST_OK || out_frame_status == ST_CRC_ERR
      || out_frame_status == ST_TOO_LONG)
    else $error("bad frame status");

endmodule

bind length_prefixed_crc32_deframer_core dfr_checker u_dfr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_result_kind      (out_result_kind),
  .out_payload_byte     (out_payload_byte),
  .out_first_of_payload (out_first_of_payload),
  .out_frame_status     (out_frame_status),
  .out_frame_length     (out_frame_length)
);

// ===== test/length_prefixed_crc32_deframer_core_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_crc32_deframer_core_tb;
  import dfr_pkg::*;

  localparam int unsigned MaxFrame = 131072;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned LongFrame = 300;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CRC     = 2'd2
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic        out_first_of_payload;
  logic [1:0]  out_frame_status;
  logic [31:0] out_frame_length;
  logic        cfg_write_en;
  logic [CfgWidth-1:0] cfg_max_payload_len;

  int unsigned in_gap_max = 5;
  int unsigned out_gap_max = 5;
  int unsigned bytes_sent = 0;
  int          errors = 0;

  dfr_result_t frame_results_due[$];
  logic [7:0]  frame_buf[$];

  // shadow of the parser
  parse_phase_e        shadow_phase;
  logic [1:0]          shadow_field_cnt;
  logic [31:0]         shadow_len;
  logic [17:0]         shadow_left;
  logic [31:0]         shadow_crc;
  logic [31:0]         shadow_rx_crc;
  logic [CfgWidth-1:0] shadow_max_len;

  length_prefixed_crc32_deframer_core #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_payload_byte     (out_payload_byte),
    .out_first_of_payload (out_first_of_payload),
    .out_frame_status     (out_frame_status),
    .out_frame_length     (out_frame_length),
    .cfg_write_en         (cfg_write_en),
    .cfg_max_payload_len  (cfg_max_payload_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bitwise reflected update, data bit i meets the register lsb
  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ d[i]) ? CrcPoly : 32'h0);
    end
    return r;
  endfunction

  function automatic logic [31:0] frame_limit();
    return (32'(shadow_max_len) < MaxFrame) ? 32'(shadow_max_len) : MaxFrame;
  endfunction

  function automatic void shadow_reset();
    shadow_phase     = PH_HEADER;
    shadow_field_cnt = 2'd0;
    shadow_len       = 32'd0;
    shadow_left      = 18'd0;
    shadow_crc       = CrcAllOnes;
    shadow_rx_crc    = 32'd0;
    shadow_max_len   = MaxPayloadReset;
  endfunction

  // advance the shadow parser by one stream byte, queue what it yields
  function automatic void deframe_byte(input logic [7:0] b);
    dfr_result_t r;
    r = '0;
    case (shadow_phase)
      PH_PAYLOAD: begin
        r.result_kind      = KIND_PAYLOAD;
        r.payload_byte     = b;
        r.first_of_payload = (32'(shadow_left) == shadow_len);
        shadow_crc  = crc32_next(shadow_crc, b);
        shadow_left = shadow_left - 18'd1;
        if (shadow_left == 18'd0) begin
          shadow_phase     = PH_CRC;
          shadow_field_cnt = 2'd0;
          shadow_rx_crc    = 32'd0;
        end
        frame_results_due.push_back(r);
      end
      PH_CRC: begin
        shadow_rx_crc    = {shadow_rx_crc[23:0], b};
        shadow_field_cnt = shadow_field_cnt + 2'd1;
        if (shadow_field_cnt == 2'd0) begin
          r.result_kind  = KIND_END;
          r.frame_status = ((shadow_crc ^ CrcAllOnes) == shadow_rx_crc) ? ST_OK : ST_CRC_ERR;
          r.frame_length = shadow_len;
          shadow_phase   = PH_HEADER;
          shadow_crc     = CrcAllOnes;
          frame_results_due.push_back(r);
        end
      end
      default: begin
        shadow_phase     = PH_HEADER;
        shadow_len       = {shadow_len[23:0], b};
        shadow_field_cnt = shadow_field_cnt + 2'd1;
        if (shadow_field_cnt == 2'd0) begin
          shadow_crc    = CrcAllOnes;
          shadow_rx_crc = 32'd0;
          if (shadow_len > frame_limit()) begin
            r.result_kind  = KIND_END;
            r.frame_status = ST_TOO_LONG;
            r.frame_length = shadow_len;
            frame_results_due.push_back(r);
          end else begin
            shadow_left  = shadow_len[17:0];
            shadow_phase = (shadow_left == 18'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      send_byte(w[8*i +: 8]);
    end
  endtask

  // header, frame_buf as payload, then the crc xored with flip
  task automatic send_frame(input logic [31:0] flip);
    logic [31:0] c;
    c = CrcAllOnes;
    foreach (frame_buf[i]) c = crc32_next(c, frame_buf[i]);
    send_word(32'(frame_buf.size()));
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
    send_word((c ^ CrcAllOnes) ^ flip);
  endtask

  task automatic fill_payload(input int unsigned n);
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // random filler until the parser is back at a header boundary
  task automatic realign();
    while (!(shadow_phase == PH_HEADER && shadow_field_cnt == 2'd0)) begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    // header bytes give no result, let them clear the pipe
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CfgWidth-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_write_en        <= 1'b1;
    cfg_max_payload_len <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    shadow_max_len = v;
  endtask

  task automatic test_zero_length();
    frame_buf.delete();
    send_frame(32'h0);
  endtask

  task automatic test_payload_extremes();
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    send_frame(32'h0);
  endtask

  task automatic test_crc_mismatch();
    frame_buf.delete();
    send_frame(32'hFFFF_FFFF);
  endtask

  task automatic test_too_long();
    send_word(32'hFFFF_FFFF);
  endtask

  task automatic test_limit_edges();
    set_limit(18'd3);
    fill_payload(3);
    send_frame(32'h0);
    send_word(32'd4);
    set_limit(18'd0);
    frame_buf.delete();
    send_frame(32'h0);
    send_word(32'd1);
    // register above the build limit, the build limit wins
    set_limit(18'h3FFFF);
    send_word(MaxFrame + 1);
  endtask

  task automatic test_random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned cap;
    int unsigned len;
    int unsigned cut;
    logic [31:0] lim;
    logic [31:0] flip;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      lim  = frame_limit();
      cap  = (lim < 20) ? lim : 20;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) begin
        in_gap_max  = 0;
        out_gap_max = 0;
      end else begin
        in_gap_max  = 5;
        out_gap_max = 5;
      end
      if ($urandom_range(0, 19) == 0 && lim <= 64) len = lim;
      else len = $urandom_range(0, cap);
      if (pick < 70) begin
        fill_payload(len);
        send_frame(32'h0);
      end else if (pick < 80) begin
        fill_payload(len);
        do flip = $urandom; while (flip == 32'h0);
        send_frame(flip);
      end else if (pick < 88) begin
        if ($urandom_range(0, 1) == 0) send_word($urandom | 32'h0100_0000);
        else send_word(lim + 1 + $urandom_range(0, 300));
      end else if (pick < 94 && len >= 2) begin
        // frame cut short inside the payload
        cut = $urandom_range(0, len - 1);
        send_word(len);
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
        realign();
      end else begin
        // stray bytes; nonzero lead makes the bogus header too long
        send_byte(8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        realign();
      end
    end
    in_gap_max  = 5;
    out_gap_max = 5;
  endtask

  // frame exactly at the configured maximum
  task automatic test_max_length_frame();
    set_limit(18'(LongFrame));
    in_gap_max  = 1;
    out_gap_max = 1;
    fill_payload(LongFrame);
    send_frame(32'h0);
    in_gap_max  = 5;
    out_gap_max = 5;
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    errors++;
  endtask

  // result side back-pressure, one draw per beat
  always begin : result_sink
    int unsigned stall;
    stall = $urandom_range(0, out_gap_max);
    @(negedge clk);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!(rst_n && out_valid));
  end

  always @(posedge clk) begin : result_check
    dfr_result_t want;
    dfr_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_result_kind, out_payload_byte, out_first_of_payload,
              out_frame_status, out_frame_length};
      if (frame_results_due.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual 0x%0h", $time, got);
        errors++;
      end else begin
        want = frame_results_due.pop_front();
        if (want.result_kind !== got.result_kind)
          flag_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        if (want.payload_byte !== got.payload_byte)
          flag_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        if (want.first_of_payload !== got.first_of_payload)
          flag_field("first_of_payload", 32'(want.first_of_payload),
                     32'(got.first_of_payload));
        if (want.frame_status !== got.frame_status)
          flag_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
        if (want.frame_length !== got.frame_length)
          flag_field("frame_length", want.frame_length, got.frame_length);
      end
    end
  end

  initial begin : run_tests
    logic [CfgWidth-1:0] sweep_limits [7];
    sweep_limits = '{18'd0, 18'd1, 18'd16, 18'd300, 18'd131071, 18'h3FFFF,
                     MaxPayloadReset};
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_rx_byte          = 8'h00;
    out_ready           = 1'b0;
    cfg_write_en        = 1'b0;
    cfg_max_payload_len = '0;
    shadow_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_length();
    test_payload_extremes();
    test_crc_mismatch();
    test_too_long();
    test_random_traffic(150);
    test_limit_edges();
    foreach (sweep_limits[i]) begin
      set_limit(sweep_limits[i]);
      test_random_traffic(150);
    end
    test_max_length_frame();

    wait_idle();
    if (errors == 0) begin
      $display("PASS length_prefixed_crc32_deframer_core");
    end else begin
      $display("FAIL length_prefixed_crc32_deframer_core");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("FAIL length_prefixed_crc32_deframer_core");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_in_stage.sv
hw/rtl/dfr_parser.sv
hw/rtl/dfr_out_stage.sv
hw/rtl/length_prefixed_crc32_deframer_core.sv
hw/rtl/dfr_checker.sv
test/length_prefixed_crc32_deframer_core_tb.sv
